[rtl/core/itk_pkg.sv]
// Shared types, codes and character-class helpers for the IDL source tokenizer.
// No dependencies; used by itk_core, itk_outbuf and idl_source_tokenizer_top.
package itk_pkg;

	// Input transaction: one source byte or the end marker
	typedef struct packed {
		logic [7:0] char_byte;
		logic       is_end;
	} in_t;

	// Output transaction: one token record
	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] start_offset;
		logic [31:0] source_length;
		logic [19:0] line_number;
		logic [7:0]  decoded_byte;
		logic [2:0]  error_code;
		logic        last_result;
	} out_t;

	localparam int MAX_RECS = 4;

	// Batch handoff from the scanner to the result buffer
	typedef struct packed {
		logic       load;
		logic [2:0] cnt;
	} batch_t;

	typedef enum logic [4:0] {
		M_IDLE, M_ERR, M_SLASH, M_LINE, M_BLOCK, M_BLOCK_STAR, M_NAME, M_INT,
		M_HEX_START, M_HEX, M_FRAC_DOT, M_FRAC, M_EXP_E, M_EXP_SIGN, M_EXP_DIGITS,
		M_DOT_PEND, M_EQ_PEND, M_STR, M_ESC, M_STR_DEC, M_STR_XPEND, M_STR_HEX,
		M_STR_XLIT
	} scan_mode_t;

	// Token kinds
	localparam logic [4:0] K_END    = 5'd0;
	localparam logic [4:0] K_NAME   = 5'd1;
	localparam logic [4:0] K_DEC    = 5'd2;
	localparam logic [4:0] K_HEX    = 5'd3;
	localparam logic [4:0] K_FLOAT  = 5'd4;
	localparam logic [4:0] K_STRING = 5'd5;
	localparam logic [4:0] K_STRBYTE = 5'd6;
	localparam logic [4:0] K_ARROW  = 5'd7;
	localparam logic [4:0] K_EQUAL  = 5'd17;
	localparam logic [4:0] K_DOT    = 5'd20;
	localparam logic [4:0] K_ERROR  = 5'd25;

	// Error codes
	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_BLOCK    = 3'd1;
	localparam logic [2:0] E_HEX      = 3'd2;
	localparam logic [2:0] E_OCTAL    = 3'd3;
	localparam logic [2:0] E_STRING   = 3'd4;
	localparam logic [2:0] E_BAD_CHAR = 3'd5;

	// Number flags
	localparam logic [2:0] FL_LEAD  = 3'b001;
	localparam logic [2:0] FL_MULTI = 3'b010;
	localparam logic [2:0] FL_FLOAT = 3'b100;

	// Characters
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_LO_X   = 8'h78;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [7:0] v;
		if (is_digit(c)) begin
			v = c - 8'h30;
		end else if (c >= 8'h61) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	// Single punctuation kind, K_ERROR when the byte is no punctuation mark
	function automatic logic [4:0] punct_kind(logic [7:0] c);
		logic [4:0] k;
		case (c)
			8'h28: k = 5'd8;
			8'h29: k = 5'd9;
			8'h7B: k = 5'd10;
			8'h7D: k = 5'd11;
			8'h3C: k = 5'd12;
			8'h3E: k = 5'd13;
			8'h2C: k = 5'd14;
			8'h3B: k = 5'd15;
			8'h40: k = 5'd16;
			8'h3D: k = 5'd17;
			8'h2D: k = 5'd18;
			8'h3F: k = 5'd19;
			8'h2E: k = 5'd20;
			8'h5B: k = 5'd21;
			8'h5D: k = 5'd22;
			8'h26: k = 5'd23;
			8'h7C: k = 5'd24;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

endpackage

[rtl/core/itk_core.sv]
// Scanner core: input register, scan state and per-byte token logic.
// Depends on itk_pkg; feeds a batch of up to four records to itk_outbuf.
module itk_core
	import itk_pkg::*;
#(
	parameter int OFFSET_BITS = 32,
	parameter int LINE_BITS = 20
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   char_valid,
	output logic   char_stall,
	input  in_t    char_item,
	input  logic   buf_free,
	output batch_t batch,
	output out_t   recs [MAX_RECS]
);

	localparam int OB = OFFSET_BITS;
	localparam int LB = LINE_BITS;
	localparam int STEPS = 5;

	typedef struct packed {
		scan_mode_t    mode;
		logic [1:0]    hcnt;
		logic [7:0]    h0;
		logic [7:0]    h1;
		logic [OB-1:0] ts;
		logic [LB-1:0] line;
		logic [LB-1:0] sline;
		logic [7:0]    esc;
		logic [2:0]    nf;
	} st_t;

	typedef struct packed {
		st_t  st;
		logic emit;
		out_t rec;
		logic adv;
	} mres_t;

	function automatic st_t rst_state();
		st_t s;
		s.mode = M_IDLE;
		s.hcnt = 2'd0;
		s.h0 = 8'd0;
		s.h1 = 8'd0;
		s.ts = '0;
		s.line = LB'(1);
		s.sline = LB'(1);
		s.esc = 8'd0;
		s.nf = 3'd0;
		return s;
	endfunction

	function automatic out_t mk_rec(logic [4:0] k, logic [OB-1:0] st, logic [OB:0] len,
			logic [LB-1:0] ln, logic [7:0] d, logic [2:0] er);
		out_t o;
		o.kind = k;
		o.start_offset = 32'(st);
		o.source_length = 32'(len);
		o.line_number = 20'(ln);
		o.decoded_byte = d;
		o.error_code = er;
		o.last_result = 1'b0;
		return o;
	endfunction

	function automatic logic [OB:0] span(logic [OB-1:0] a, logic [OB-1:0] b);
		return {1'b0, a} - {1'b0, b};
	endfunction

	function automatic logic [LB-1:0] line_inc(logic [LB-1:0] l);
		return (l == '1) ? l : l + LB'(1);
	endfunction

	// Close a number ending at offset e; the caller rescans the symbol
	function automatic mres_t finish(st_t s, logic [OB-1:0] e);
		mres_t r;
		r.st = s;
		r.st.mode = M_IDLE;
		r.emit = 1'b1;
		r.adv = 1'b0;
		if (s.nf[2]) begin
			r.rec = mk_rec(K_FLOAT, s.ts, span(e, s.ts), s.line, 8'd0, E_NONE);
		end else if (s.nf[0] && s.nf[1]) begin
			r.rec = mk_rec(K_ERROR, s.ts, '0, s.line, 8'd0, E_OCTAL);
			r.st.mode = M_ERR;
		end else begin
			r.rec = mk_rec(K_DEC, s.ts, span(e, s.ts), s.line, 8'd0, E_NONE);
		end
		return r;
	endfunction

	// One scan step: consumes the symbol, or rescans it in the new mode
	function automatic mres_t mstep(st_t s, logic e, logic [7:0] c, logic [OB-1:0] off);
		mres_t r;
		logic dg, hx, lf, ee, pk_ok;
		logic [4:0] pk;
		r.st = s;
		r.emit = 1'b0;
		r.rec = '0;
		r.adv = 1'b1;
		dg = !e && is_digit(c);
		hx = !e && is_hex(c);
		lf = !e && (c == CH_LF);
		ee = !e && ((c == CH_LO_E) || (c == CH_UP_E));
		pk = punct_kind(c);
		pk_ok = (pk != K_ERROR);
		unique case (s.mode)
			M_ERR: begin
			end
			M_IDLE: begin
				if (e) begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_END, off, '0, s.line, 8'd0, E_NONE);
				end else if (lf) begin
					r.st.line = line_inc(s.line);
				end else if (!is_space(c)) begin
					r.st.ts = off;
					if (c == CH_SLASH) begin
						r.st.mode = M_SLASH;
					end else if (is_alpha(c) || c == CH_USCORE) begin
						r.st.mode = M_NAME;
					end else if (dg) begin
						r.st.nf = (c == CH_ZERO) ? FL_LEAD : 3'd0;
						r.st.mode = M_INT;
					end else if (c == CH_DOT) begin
						r.st.mode = M_DOT_PEND;
					end else if (c == CH_QUOTE) begin
						r.st.sline = s.line;
						r.st.mode = M_STR;
					end else if (c == CH_EQUAL) begin
						r.st.mode = M_EQ_PEND;
					end else if (pk_ok) begin
						r.emit = 1'b1;
						r.rec = mk_rec(pk, off, (OB+1)'(1), s.line, 8'd0, E_NONE);
					end else begin
						r.emit = 1'b1;
						r.rec = mk_rec(K_ERROR, off, '0, s.line, 8'd0, E_BAD_CHAR);
						r.st.mode = M_ERR;
					end
				end
			end
			M_SLASH: begin
				if (!e && c == CH_SLASH) begin
					r.st.mode = M_LINE;
				end else if (!e && c == CH_STAR) begin
					r.st.mode = M_BLOCK;
				end else begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_ERROR, s.ts, '0, s.line, 8'd0, E_BAD_CHAR);
					r.st.mode = M_ERR;
				end
			end
			M_LINE: begin
				if (lf || e) begin
					r.st.mode = M_IDLE;
					r.adv = 1'b0;
				end
			end
			M_BLOCK, M_BLOCK_STAR: begin
				if (e) begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_ERROR, s.ts, '0, s.line, 8'd0, E_BLOCK);
					r.st.mode = M_ERR;
				end else if (c == CH_SLASH && s.mode == M_BLOCK_STAR) begin
					r.st.mode = M_IDLE;
				end else if (c == CH_STAR) begin
					r.st.mode = M_BLOCK_STAR;
				end else begin
					if (lf) r.st.line = line_inc(s.line);
					r.st.mode = M_BLOCK;
				end
			end
			M_NAME: begin
				if (!(!e && (is_alpha(c) || is_digit(c) || c == CH_USCORE))) begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_NAME, s.ts, span(off, s.ts), s.line, 8'd0, E_NONE);
					r.st.mode = M_IDLE;
					r.adv = 1'b0;
				end
			end
			M_INT: begin
				if (dg) begin
					r.st.nf = s.nf | FL_MULTI;
				end else if (!e && c == CH_DOT) begin
					r.st.h0 = c;
					r.st.hcnt = 2'd1;
					r.st.mode = M_FRAC_DOT;
				end else if (ee) begin
					r.st.h0 = c;
					r.st.hcnt = 2'd1;
					r.st.mode = M_EXP_E;
				end else if (!e && (c == CH_LO_X || c == CH_UP_X) && s.nf == FL_LEAD) begin
					r.st.mode = M_HEX_START;
				end else begin
					r = finish(s, off);
				end
			end
			M_HEX_START: begin
				if (hx) begin
					r.st.mode = M_HEX;
				end else begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_ERROR, s.ts, '0, s.line, 8'd0, E_HEX);
					r.st.mode = M_ERR;
				end
			end
			M_HEX: begin
				if (!hx) begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_HEX, s.ts, span(off, s.ts), s.line, 8'd0, E_NONE);
					r.st.mode = M_IDLE;
					r.adv = 1'b0;
				end
			end
			M_FRAC_DOT, M_EXP_SIGN: begin
				if (dg) begin
					r.st.nf = s.nf | FL_FLOAT;
					r.st.hcnt = 2'd0;
					r.st.mode = (s.mode == M_FRAC_DOT) ? M_FRAC : M_EXP_DIGITS;
				end else begin
					// give back: off is the first held byte's offset here
					r = finish(s, off);
					r.st.hcnt = 2'd0;
				end
			end
			M_FRAC: begin
				if (ee) begin
					r.st.h0 = c;
					r.st.hcnt = 2'd1;
					r.st.mode = M_EXP_E;
				end else if (!dg) begin
					r = finish(s, off);
				end
			end
			M_EXP_E: begin
				if (!e && (c == CH_PLUS || c == CH_MINUS)) begin
					r.st.h1 = c;
					r.st.hcnt = 2'd2;
					r.st.mode = M_EXP_SIGN;
				end else if (dg) begin
					r.st.nf = s.nf | FL_FLOAT;
					r.st.hcnt = 2'd0;
					r.st.mode = M_EXP_DIGITS;
				end else begin
					r = finish(s, off);
					r.st.hcnt = 2'd0;
				end
			end
			M_EXP_DIGITS: begin
				if (!dg) r = finish(s, off);
			end
			M_DOT_PEND: begin
				if (dg) begin
					r.st.nf = FL_FLOAT;
					r.st.mode = M_FRAC;
				end else begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_DOT, s.ts, (OB+1)'(1), s.line, 8'd0, E_NONE);
					r.st.mode = M_IDLE;
					r.adv = 1'b0;
				end
			end
			M_EQ_PEND: begin
				r.st.mode = M_IDLE;
				r.emit = 1'b1;
				if (!e && c == CH_GT) begin
					r.rec = mk_rec(K_ARROW, s.ts, (OB+1)'(2), s.line, 8'd0, E_NONE);
				end else begin
					r.rec = mk_rec(K_EQUAL, s.ts, (OB+1)'(1), s.line, 8'd0, E_NONE);
					r.adv = 1'b0;
				end
			end
			M_STR: begin
				if (!e && c == CH_QUOTE) begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_STRING, s.ts, span(off, s.ts) + (OB+1)'(1), s.line,
						8'd0, E_NONE);
					r.st.mode = M_IDLE;
				end else if (lf || e) begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_ERROR, s.ts, '0, s.sline, 8'd0, E_STRING);
					r.st.mode = M_ERR;
				end else if (c == CH_BSLASH) begin
					r.st.mode = M_ESC;
				end else begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_STRBYTE, s.ts, '0, s.line, c, E_NONE);
				end
			end
			M_ESC: begin
				if (!e && (c == CH_QUOTE || c == CH_BSLASH)) begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_STRBYTE, s.ts, '0, s.line, c, E_NONE);
					r.st.mode = M_STR;
				end else if (dg) begin
					r.st.esc = {4'd0, c[3:0]};
					r.st.mode = M_STR_DEC;
				end else if (!e && c == CH_LO_X) begin
					r.st.mode = M_STR_XPEND;
				end else begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_STRBYTE, s.ts, '0, s.line, CH_BSLASH, E_NONE);
					r.st.mode = M_STR;
					r.adv = 1'b0;
				end
			end
			M_STR_DEC: begin
				if (dg) begin
					r.st.esc = 8'(s.esc * 8'd10) + {4'd0, c[3:0]};
				end else begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_STRBYTE, s.ts, '0, s.line, s.esc, E_NONE);
					r.st.mode = M_STR;
					r.adv = 1'b0;
				end
			end
			M_STR_XPEND: begin
				if (hx) begin
					r.st.esc = {4'd0, hex_val(c)};
					r.st.mode = M_STR_HEX;
				end else begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_STRBYTE, s.ts, '0, s.line, CH_BSLASH, E_NONE);
					r.st.mode = M_STR_XLIT;
					r.adv = 1'b0;
				end
			end
			M_STR_XLIT: begin
				r.emit = 1'b1;
				r.rec = mk_rec(K_STRBYTE, s.ts, '0, s.line, CH_LO_X, E_NONE);
				r.st.mode = M_STR;
				r.adv = 1'b0;
			end
			M_STR_HEX: begin
				if (hx) begin
					r.st.esc = {s.esc[3:0], hex_val(c)};
				end else begin
					r.emit = 1'b1;
					r.rec = mk_rec(K_STRBYTE, s.ts, '0, s.line, s.esc, E_NONE);
					r.st.mode = M_STR;
					r.adv = 1'b0;
				end
			end
			default: begin
				r.st.mode = M_IDLE;
				r.adv = 1'b0;
			end
		endcase
		return r;
	endfunction

	// Input register and scan state
	logic          v_s1;
	in_t           item_s1;
	st_t           st_q;
	logic [OB-1:0] off_q;

	logic          commit;
	logic          gb;
	logic [1:0]    n_held;
	logic [1:0]    qlen;
	logic          qe [4];
	logic [7:0]    qc [4];
	logic [OB-1:0] qoff [4];
	st_t           st_nxt;
	logic [2:0]    cnt;
	out_t          recs_c [MAX_RECS];

	// Symbol queue: held lookahead bytes are replayed ahead of the new byte
	always_comb begin
		gb = 1'b0;
		if (st_q.mode == M_FRAC_DOT || st_q.mode == M_EXP_SIGN) begin
			gb = item_s1.is_end || !is_digit(item_s1.char_byte);
		end else if (st_q.mode == M_EXP_E) begin
			gb = item_s1.is_end || !(is_digit(item_s1.char_byte) ||
				item_s1.char_byte == CH_PLUS || item_s1.char_byte == CH_MINUS);
		end
		n_held = gb ? st_q.hcnt : 2'd0;
		if (n_held > 2'd2) n_held = 2'd2;
		qlen = n_held + 2'd1;
		qe[0] = (n_held == 2'd0) ? item_s1.is_end : 1'b0;
		qc[0] = (n_held == 2'd0) ? item_s1.char_byte : st_q.h0;
		qe[1] = (n_held == 2'd2) ? 1'b0 : item_s1.is_end;
		qc[1] = (n_held == 2'd2) ? st_q.h1 : item_s1.char_byte;
		qe[2] = item_s1.is_end;
		qc[2] = item_s1.char_byte;
		qe[3] = item_s1.is_end;
		qc[3] = item_s1.char_byte;
		qoff[0] = off_q - OB'(n_held);
		qoff[1] = off_q - OB'(n_held) + OB'(1);
		qoff[2] = off_q;
		qoff[3] = off_q;
	end

	// Scan steps for one input byte, records collected in order
	always_comb begin
		st_t        s;
		mres_t      r;
		logic [1:0] pos;
		logic       done;
		s = st_q;
		pos = 2'd0;
		done = 1'b0;
		cnt = 3'd0;
		for (int k = 0; k < MAX_RECS; k++) recs_c[k] = '0;
		for (int i = 0; i < STEPS; i++) begin
			if (!done) begin
				r = mstep(s, qe[pos], qc[pos], qoff[pos]);
				s = r.st;
				if (r.emit && cnt < 3'(MAX_RECS)) begin
					recs_c[cnt[1:0]] = r.rec;
					cnt = cnt + 3'd1;
				end
				if (r.adv) begin
					if (pos + 2'd1 == qlen) done = 1'b1;
					else pos = pos + 2'd1;
				end
			end
		end
		st_nxt = item_s1.is_end ? rst_state() : s;
	end

	assign commit = v_s1 && (cnt == 3'd0 || buf_free);
	assign char_stall = v_s1 && !commit;
	assign batch.load = commit && (cnt != 3'd0);
	assign batch.cnt = cnt;
	assign recs = recs_c;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			v_s1 <= 1'b1;
		end else if (commit) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) item_s1 <= char_item;
	end

	// Scan state and byte offset, updated when the item commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rst_state();
			off_q <= '0;
		end else if (commit) begin
			st_q <= st_nxt;
			if (item_s1.is_end) off_q <= '0;
			else if (off_q != '1) off_q <= off_q + OB'(1);
		end
	end

endmodule

[rtl/core/itk_outbuf.sv]
// Result buffer: holds one batch of up to four token records and drains
// them one per transaction. Depends on itk_pkg.
module itk_outbuf
	import itk_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  batch_t batch,
	input  out_t   recs [MAX_RECS],
	output logic   buf_free,
	output logic   tok_valid,
	input  logic   tok_stall,
	output out_t   tok_item
);

	logic [2:0] n_q;
	logic [2:0] rd_q;
	out_t       recs_q [MAX_RECS];
	logic       drain;

	assign tok_valid = (rd_q != n_q);
	assign drain = tok_valid && !tok_stall;
	assign buf_free = (rd_q == n_q) || (drain && (rd_q + 3'd1 == n_q));

	// Current record, flagged when it closes the batch
	always_comb begin
		tok_item = recs_q[rd_q[1:0]];
		tok_item.last_result = (rd_q + 3'd1 == n_q);
	end

	// Batch pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 3'd0;
			rd_q <= 3'd0;
		end else if (batch.load) begin
			n_q <= batch.cnt;
			rd_q <= 3'd0;
		end else if (drain) begin
			rd_q <= rd_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (batch.load) recs_q <= recs;
	end

	// Read pointer never passes the fill count
	a_rd_le_n: assert property (@(posedge clk) disable iff (!arst_n) rd_q <= n_q)
		else $error("read pointer past batch end");

	// A batch never overwrites records still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		batch.load |-> buf_free)
		else $error("batch loaded over pending records");

	// A loaded batch is non-empty and within the buffer depth
	a_load_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		batch.load |=> (n_q != 3'd0 && n_q <= 3'(MAX_RECS) && rd_q == 3'd0))
		else $error("bad batch size");

endmodule

[rtl/core/idl_source_tokenizer_top.sv]
// Top level of the IDL source tokenizer: scanner core plus result buffer.
// Depends on itk_pkg, itk_core and itk_outbuf.
//
//  channel | dir | handshake              | payload
//  char    | in  | char_valid/char_stall  | char_item (in_t): char_byte, is_end
//  tok     | out | tok_valid/tok_stall    | tok_item (out_t): one token record
//
// One byte is taken per cycle unless stalled; it is registered, then its records
// load the result buffer. A later byte with records holds the input while the
// buffer drains, since the output moves one record per cycle when not stalled.
// Reset is asynchronous; it leaves the scanner idle at offset 0, line 1.
// A stalled output keeps its record and stalls the input once the buffer is due.
module idl_source_tokenizer_top
	import itk_pkg::*;
#(
	parameter int OFFSET_BITS = 32,
	parameter int LINE_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic char_valid,
	output logic char_stall,
	input  in_t  char_item,
	output logic tok_valid,
	input  logic tok_stall,
	output out_t tok_item
);

	batch_t batch;
	out_t   recs [MAX_RECS];
	logic   buf_free;

	itk_core #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS(LINE_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_item(char_item),
		.buf_free(buf_free),
		.batch(batch),
		.recs(recs)
	);

	itk_outbuf u_outbuf (
		.clk(clk),
		.arst_n(arst_n),
		.batch(batch),
		.recs(recs),
		.buf_free(buf_free),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_item(tok_item)
	);

endmodule

[tb/idl_source_tokenizer_top_tb.sv]
// Testbench for idl_source_tokenizer_top: directed and random source text,
// a self-contained scanner predictor and an in-order token scoreboard.
// Depends on itk_pkg and the tokenizer RTL.
module idl_source_tokenizer_top_tb
	import itk_pkg::*;
();

	// Token scoreboard: holds predicted records, checks each received one
	class token_board;
		out_t expected_q[$];
		int errors;

		function void note_input(out_t recs[$]);
			foreach (recs[i]) expected_q = {expected_q, recs[i]};
		endfunction

		task check_token(out_t got);
			out_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("token with nothing expected", '0, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.kind != want.kind) report_mismatch("kind", want, got);
			if (got.start_offset != want.start_offset) report_mismatch("start_offset", want, got);
			if (got.source_length != want.source_length)
				report_mismatch("source_length", want, got);
			if (got.line_number != want.line_number) report_mismatch("line_number", want, got);
			if (got.decoded_byte != want.decoded_byte) report_mismatch("decoded_byte", want, got);
			if (got.error_code != want.error_code) report_mismatch("error_code", want, got);
			if (got.last_result != want.last_result) report_mismatch("last_result", want, got);
		endtask

		task report_mismatch(string what, out_t want, out_t got);
			errors++;
			$display("MISMATCH %s: want %h got %h", what, want, got);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic char_valid = 0;
	logic char_stall;
	in_t  char_item = '0;
	logic tok_valid;
	logic tok_stall = 0;
	out_t tok_item;

	idl_source_tokenizer_top uut (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_stall(char_stall), .char_item(char_item),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .tok_item(tok_item)
	);

	always #2 clk = ~clk;

	token_board board = new();
	int idle_cycles = 0;
	bit hold_rx = 0;

	// Predictor state
	scan_mode_t sc_mode = M_IDLE;
	logic [7:0] sc_held[2];
	int unsigned sc_held_n = 0;
	logic [31:0] sc_off = '0, sc_start = '0;
	logic [19:0] sc_line = 20'd1, sc_str_line = 20'd1;
	logic [7:0] sc_esc = '0;
	logic [2:0] sc_flags = '0;
	out_t sc_recs[$];

	function automatic bit c_digit(int c); return c >= 8'h30 && c <= 8'h39; endfunction
	function automatic bit c_alpha(int c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction
	function automatic bit c_hex(int c);
		return c_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction
	function automatic logic [7:0] c_hexval(int c);
		if (c_digit(c)) return 8'(c - 'h30);
		if (c >= 8'h61) return 8'(c - 'h57);
		return 8'(c - 'h37);
	endfunction
	function automatic logic [4:0] c_punct(int c);
		case (c)
			8'h28: return 5'd8;  8'h29: return 5'd9;  8'h7B: return 5'd10;
			8'h7D: return 5'd11; 8'h3C: return 5'd12; 8'h3E: return 5'd13;
			8'h2C: return 5'd14; 8'h3B: return 5'd15; 8'h40: return 5'd16;
			8'h3D: return 5'd17; 8'h2D: return 5'd18; 8'h3F: return 5'd19;
			8'h2E: return 5'd20; 8'h5B: return 5'd21; 8'h5D: return 5'd22;
			8'h26: return 5'd23; 8'h7C: return 5'd24;
			default: return K_ERROR;
		endcase
	endfunction

	localparam int END_SYM = 256;

	function automatic void add_rec(logic [4:0] k, logic [31:0] s, logic [31:0] len,
		logic [19:0] ln, logic [7:0] d, logic [2:0] e);
		out_t r;
		if (sc_recs.size() >= MAX_RECS) return;
		r = '{k, s, len, ln, d, e, 1'b0};
		sc_recs = {sc_recs, r};
	endfunction

	function automatic void raise_error(logic [2:0] e, logic [31:0] s, logic [19:0] ln);
		add_rec(K_ERROR, s, '0, ln, '0, e);
		sc_mode = M_ERR;
	endfunction

	function automatic void line_up();
		if (sc_line != 20'hFFFFF) sc_line++;
	endfunction

	function automatic void close_number(logic [31:0] fin);
		sc_mode = M_IDLE;
		if (sc_flags & FL_FLOAT) add_rec(K_FLOAT, sc_start, fin - sc_start, sc_line, '0, E_NONE);
		else if ((sc_flags & FL_LEAD) && (sc_flags & FL_MULTI))
			raise_error(E_OCTAL, sc_start, sc_line);
		else add_rec(K_DEC, sc_start, fin - sc_start, sc_line, '0, E_NONE);
	endfunction

	function automatic void scan_idle(int ch, logic [31:0] off);
		if (ch == END_SYM) begin add_rec(K_END, off, '0, sc_line, '0, E_NONE); return; end
		if (ch == CH_LF) begin line_up(); return; end
		if (ch == 8'h20 || (ch >= 9 && ch <= 13)) return;
		sc_start = off;
		if (ch == CH_SLASH) sc_mode = M_SLASH;
		else if (c_alpha(ch) || ch == CH_USCORE) sc_mode = M_NAME;
		else if (c_digit(ch)) begin
			sc_flags = (ch == CH_ZERO) ? FL_LEAD : 3'b0;
			sc_mode = M_INT;
		end else if (ch == CH_DOT) sc_mode = M_DOT_PEND;
		else if (ch == CH_QUOTE) begin sc_str_line = sc_line; sc_mode = M_STR; end
		else if (ch == CH_EQUAL) sc_mode = M_EQ_PEND;
		else if (c_punct(ch) != K_ERROR) add_rec(c_punct(ch), off, 32'd1, sc_line, '0, E_NONE);
		else raise_error(E_BAD_CHAR, off, sc_line);
	endfunction

	function automatic void str_rec(logic [7:0] v);
		add_rec(K_STRBYTE, sc_start, '0, sc_line, v, E_NONE);
	endfunction

	// Replay held exponent/dot bytes after a number that stops short
	function automatic void replay_held(int ch, logic [31:0] off);
		logic [7:0] h[2];
		int unsigned n;
		logic [31:0] base;
		n = sc_held_n;
		h = sc_held;
		base = off - 32'(n);
		sc_held_n = 0;
		close_number(base);
		for (int k = 0; k < n; k++) scan_byte(int'(h[k]), base + 32'(k));
		scan_byte(ch, off);
	endfunction

	function automatic void scan_byte(int ch, logic [31:0] off);
		case (sc_mode)
			M_ERR: ;
			M_IDLE: scan_idle(ch, off);
			M_SLASH: begin
				if (ch == CH_SLASH) sc_mode = M_LINE;
				else if (ch == CH_STAR) sc_mode = M_BLOCK;
				else raise_error(E_BAD_CHAR, sc_start, sc_line);
			end
			M_LINE: begin
				if (ch == CH_LF || ch == END_SYM) begin sc_mode = M_IDLE; scan_idle(ch, off); end
			end
			M_BLOCK, M_BLOCK_STAR: begin
				if (ch == END_SYM) raise_error(E_BLOCK, sc_start, sc_line);
				else if (ch == CH_SLASH && sc_mode == M_BLOCK_STAR) sc_mode = M_IDLE;
				else if (ch == CH_STAR) sc_mode = M_BLOCK_STAR;
				else begin
					if (ch == CH_LF) line_up();
					sc_mode = M_BLOCK;
				end
			end
			M_NAME: begin
				if (!(c_alpha(ch) || c_digit(ch) || ch == CH_USCORE)) begin
					add_rec(K_NAME, sc_start, off - sc_start, sc_line, '0, E_NONE);
					sc_mode = M_IDLE;
					scan_idle(ch, off);
				end
			end
			M_INT: begin
				if (c_digit(ch)) sc_flags |= FL_MULTI;
				else if (ch == CH_DOT) begin
					sc_held[0] = 8'(ch); sc_held_n = 1; sc_mode = M_FRAC_DOT;
				end else if (ch == CH_LO_E || ch == CH_UP_E) begin
					sc_held[0] = 8'(ch); sc_held_n = 1; sc_mode = M_EXP_E;
				end else if ((ch == CH_LO_X || ch == CH_UP_X) && sc_flags == FL_LEAD)
					sc_mode = M_HEX_START;
				else begin
					close_number(off);
					if (sc_mode == M_IDLE) scan_idle(ch, off);
				end
			end
			M_HEX_START: begin
				if (c_hex(ch)) sc_mode = M_HEX;
				else raise_error(E_HEX, sc_start, sc_line);
			end
			M_HEX: begin
				if (!c_hex(ch)) begin
					add_rec(K_HEX, sc_start, off - sc_start, sc_line, '0, E_NONE);
					sc_mode = M_IDLE;
					scan_idle(ch, off);
				end
			end
			M_FRAC_DOT: begin
				if (c_digit(ch)) begin sc_flags |= FL_FLOAT; sc_held_n = 0; sc_mode = M_FRAC; end
				else replay_held(ch, off);
			end
			M_FRAC: begin
				if (ch == CH_LO_E || ch == CH_UP_E) begin
					sc_held[0] = 8'(ch); sc_held_n = 1; sc_mode = M_EXP_E;
				end else if (!c_digit(ch)) begin
					close_number(off);
					if (sc_mode == M_IDLE) scan_idle(ch, off);
				end
			end
			M_EXP_E: begin
				if (ch == CH_PLUS || ch == CH_MINUS) begin
					sc_held[1] = 8'(ch); sc_held_n = 2; sc_mode = M_EXP_SIGN;
				end else if (c_digit(ch)) begin
					sc_flags |= FL_FLOAT; sc_held_n = 0; sc_mode = M_EXP_DIGITS;
				end else replay_held(ch, off);
			end
			M_EXP_SIGN: begin
				if (c_digit(ch)) begin
					sc_flags |= FL_FLOAT; sc_held_n = 0; sc_mode = M_EXP_DIGITS;
				end else replay_held(ch, off);
			end
			M_EXP_DIGITS: begin
				if (!c_digit(ch)) begin
					close_number(off);
					if (sc_mode == M_IDLE) scan_idle(ch, off);
				end
			end
			M_DOT_PEND: begin
				if (c_digit(ch)) begin sc_flags = FL_FLOAT; sc_mode = M_FRAC; end
				else begin
					add_rec(K_DOT, sc_start, 32'd1, sc_line, '0, E_NONE);
					sc_mode = M_IDLE;
					scan_idle(ch, off);
				end
			end
			M_EQ_PEND: begin
				sc_mode = M_IDLE;
				if (ch == CH_GT) add_rec(K_ARROW, sc_start, 32'd2, sc_line, '0, E_NONE);
				else begin
					add_rec(K_EQUAL, sc_start, 32'd1, sc_line, '0, E_NONE);
					scan_idle(ch, off);
				end
			end
			M_STR: begin
				if (ch == CH_QUOTE) begin
					add_rec(K_STRING, sc_start, off + 32'd1 - sc_start, sc_line, '0, E_NONE);
					sc_mode = M_IDLE;
				end else if (ch == CH_LF || ch == END_SYM)
					raise_error(E_STRING, sc_start, sc_str_line);
				else if (ch == CH_BSLASH) sc_mode = M_ESC;
				else str_rec(8'(ch));
			end
			M_ESC: begin
				if (ch == CH_QUOTE || ch == CH_BSLASH) begin str_rec(8'(ch)); sc_mode = M_STR; end
				else if (c_digit(ch)) begin sc_esc = 8'(ch - 'h30); sc_mode = M_STR_DEC; end
				else if (ch == CH_LO_X) sc_mode = M_STR_XPEND;
				else begin str_rec(CH_BSLASH); sc_mode = M_STR; scan_byte(ch, off); end
			end
			M_STR_DEC: begin
				if (c_digit(ch)) sc_esc = 8'(sc_esc * 8'd10 + 8'(ch - 'h30));
				else begin str_rec(sc_esc); sc_mode = M_STR; scan_byte(ch, off); end
			end
			M_STR_XPEND: begin
				if (c_hex(ch)) begin sc_esc = c_hexval(ch); sc_mode = M_STR_HEX; end
				else begin
					str_rec(CH_BSLASH); str_rec(CH_LO_X);
					sc_mode = M_STR; scan_byte(ch, off);
				end
			end
			M_STR_HEX: begin
				if (c_hex(ch)) sc_esc = 8'(sc_esc * 8'd16 + c_hexval(ch));
				else begin str_rec(sc_esc); sc_mode = M_STR; scan_byte(ch, off); end
			end
			default: begin sc_mode = M_IDLE; scan_idle(ch, off); end
		endcase
	endfunction

	function automatic void restart_scan();
		sc_mode = M_IDLE; sc_held_n = 0; sc_held[0] = '0; sc_held[1] = '0;
		sc_off = '0; sc_start = '0; sc_line = 20'd1; sc_str_line = 20'd1;
		sc_esc = '0; sc_flags = '0;
	endfunction

	// Predict records for one accepted transaction
	function automatic void predict_tokens(in_t it);
		sc_recs.delete();
		scan_byte(it.is_end ? END_SYM : int'(it.char_byte), sc_off);
		if (it.is_end) restart_scan();
		else if (sc_off != 32'hFFFFFFFF) sc_off++;
		if (sc_recs.size() > 0) sc_recs[sc_recs.size()-1].last_result = 1'b1;
		board.note_input(sc_recs);
	endfunction

	// Stimulus text
	logic [8:0] text_q[$];
	int burst_left = 0;

	function automatic void put_sym(logic [8:0] sym);
		text_q = {text_q, sym};
	endfunction

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) put_sym({1'b0, s[i]});
	endtask

	task automatic add_end(); put_sym(9'h100); endtask

	// Sender: bursts with random gaps; predicts at acceptance
	task automatic send_item(logic [8:0] sym);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				char_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		char_valid <= 1;
		char_item <= '{char_byte: sym[8] ? 8'($urandom) : sym[7:0], is_end: sym[8]};
		@(posedge clk);
		while (char_stall) @(posedge clk);
		predict_tokens(in_t'{char_byte: sym[7:0], is_end: sym[8]});
	endtask

	task automatic drain_text();
		while (text_q.size() > 0) send_item(text_q.pop_front());
		char_valid <= 0;
		burst_left = 0;
		@(posedge clk);
	endtask

	string frag[] = '{"name_1", "0x1F", "0X", "07", "0", "3.25", "1.e", "2e+", "4E-7", "5.x",
		".5e3", ".", "=>", "=", "(){}<>,;@-?[]&|", "\"ab\\\"\\\\\"", "\"\\300\"", "\"\\x1g\"",
		"\"\\xZ\"", "\"\\q\"", "// note\n", "/* a\n*b */", "/x", "\n", " \t", "12e5 ",
		"\"unterminated\n", "#", "0x", "\"abc"};

	// Random text: mostly well-formed fragments, some raw bytes
	task automatic add_random_text(int n);
		int target;
		target = text_q.size() + n;
		while (text_q.size() < target) begin
			if ($urandom_range(0, 9) < 7) add_text(frag[$urandom_range(0, frag.size()-1)]);
			else put_sym({1'b0, 8'($urandom)});
			if ($urandom_range(0, 3) == 0) add_text(" ");
		end
		add_end();
	endtask

	// Receiver stall pattern, with optional long hold-off
	always @(posedge clk) begin
		if (hold_rx) tok_stall <= 1;
		else tok_stall <= ($urandom_range(0, 15) < 5) && ($urandom_range(0, 3) != 0);
	end

	// Checker and watchdog
	always @(posedge clk) begin
		if (arst_n && tok_valid && !tok_stall) board.check_token(tok_item);
		if ((char_valid && !char_stall) || (tok_valid && !tok_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes and special cases
		add_text("ab_9 0x1fA 1.5e+3 0 07 .7 . => = 1.e5x 2e+q \"a\\x4g\\256\\z\\\"\" ");
		add_text("/*c*/ // l\n/q");
		add_end();
		put_sym({1'b0, 8'hFF});
		put_sym({1'b0, 8'h80});
		add_end();
		add_text("/* open");
		add_end();
		drain_text();

		// Sender pauses until every record has come
		wait (board.expected_q.size() == 0);
		repeat (4) @(posedge clk);

		// Long receiver hold-off while the sender keeps going
		fork
			begin
				hold_rx = 1;
				repeat (60) @(posedge clk);
				hold_rx = 0;
			end
			begin
				add_text("\"\\x\\x\\x\\x\" (((((((((((((");
				add_end();
				drain_text();
			end
		join

		for (int r = 0; r < 6; r++) begin
			add_random_text(14);
			drain_text();
		end

		wait (board.expected_q.size() == 0);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.expected_q.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
